// File: rtl/okrl_pkg.sv
// Shared types and codes for the ordered keyed record list.
`timescale 1ns / 1ps

package okrl_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 16;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_SHOW   = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_DELETE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic signed [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		status_t                 status;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} result_t;

endpackage

// File: rtl/ordered_keyed_record_list.sv
// Top level of the ordered keyed record list.
`timescale 1ns / 1ps

// Keeps an ordered list of up to DEPTH records (32-bit key, signed Q7.8 value)
// in a single-port-read record memory and runs one command at a time. A new
// request is taken whenever the sequencer is idle, even while a result waits in
// the output register. An append passes through accept, execute and emit.
// Update and delete read and compare one entry at a time, a read in S_RD
// ahead of each compare in S_CMP, until a match or the last record; delete
// then moves each later record up by one place in the same way. Show reads
// and emits each record in turn and waits while the output side stalls.
// Each compare works on the memory's registered read data.
// The record memory needs no clearing after reset.
module ordered_keyed_record_list #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // key[31:0], value[47:32]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // key_out[31:0], value_out[47:32]
	output logic [1:0]  m_tuser,   // status[1:0]
	output logic        m_tlast
);
	import okrl_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;
	logic             res_free;
	logic             res_push;
	result_t          res;
	result_t          res_out;

	okrl_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	okrl_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_cmd   (cmd_t'(s_tuser)),
		.req_key   (s_tdata[31:0]),
		.req_value (s_tdata[47:32]),
		.res_free  (res_free),
		.res_push  (res_push),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	okrl_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.free   (res_free),
		.valid  (m_tvalid),
		.ready  (m_tready),
		.dout   (res_out)
	);

	assign m_tdata = {res_out.value, res_out.key};
	assign m_tuser = res_out.status;
	assign m_tlast = res_out.last;

endmodule

// File: rtl/okrl_mem.sv
// Record store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module okrl_mem #(
	parameter int DEPTH = 16,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  okrl_pkg::entry_t  wdata,
	input  logic              re,
	input  logic [IDX_W-1:0]  raddr,
	output okrl_pkg::entry_t  rdata
);
	import okrl_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/okrl_ctrl.sv
// Command sequencer: walks the record store to append, show, update and delete.
`timescale 1ns / 1ps

module okrl_ctrl #(
	parameter int DEPTH = 16,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  okrl_pkg::cmd_t                      req_cmd,
	input  logic signed [okrl_pkg::KEY_W-1:0]   req_key,
	input  logic signed [okrl_pkg::VAL_W-1:0]   req_value,
	input  logic                                res_free,
	output logic                                res_push,
	output okrl_pkg::result_t                   res,
	output logic                                mem_we,
	output logic [IDX_W-1:0]                    mem_waddr,
	output okrl_pkg::entry_t                    mem_wdata,
	output logic                                mem_re,
	output logic [IDX_W-1:0]                    mem_raddr,
	input  okrl_pkg::entry_t                    mem_rdata
);
	import okrl_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_RD   = 5'b00100,
		S_CMP  = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t                  state_q;
	cmd_t                    cmd_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [VAL_W-1:0] value_q;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    shift_q;
	status_t                 res_status_q;
	logic signed [KEY_W-1:0] res_key_q;
	logic signed [VAL_W-1:0] res_value_q;

	logic is_full;
	logic is_empty;
	logic is_tail;
	logic match;

	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign is_tail  = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign match    = (mem_rdata.key == key_q);

	assign req_ready = (state_q == S_IDLE);

	assign mem_re    = (state_q == S_RD);
	assign mem_raddr = idx_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '{value: value_q, key: key_q};
		if (state_q == S_EXEC && cmd_q == CMD_APPEND && !is_full) begin
			mem_we    = 1'b1;
			mem_waddr = count_q[IDX_W-1:0];
		end else if (state_q == S_CMP && cmd_q == CMD_UPDATE && match) begin
			mem_we = 1'b1;
		end else if (state_q == S_CMP && cmd_q == CMD_DELETE && shift_q) begin
			// move the entry just read up by one place
			mem_we    = 1'b1;
			mem_waddr = idx_q - IDX_W'(1);
			mem_wdata = mem_rdata;
		end
	end

	always_comb begin
		res_push = 1'b0;
		res      = '{status: res_status_q, key: res_key_q, value: res_value_q, last: 1'b1};
		if (state_q == S_CMP && cmd_q == CMD_SHOW) begin
			res_push = res_free;
			res      = '{status: ST_OK, key: mem_rdata.key, value: mem_rdata.value,
				last: is_tail};
		end else if (state_q == S_EMIT) begin
			res_push = res_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			shift_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					idx_q   <= '0;
					shift_q <= 1'b0;
					case (cmd_q)
						CMD_APPEND: begin
							if (!is_full) begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= S_EMIT;
						end
						default: begin
							state_q <= is_empty ? S_EMIT : S_RD;
						end
					endcase
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					case (cmd_q)
						CMD_SHOW: begin
							if (res_free) begin
								state_q <= is_tail ? S_IDLE : S_RD;
								idx_q   <= idx_q + IDX_W'(1);
							end
						end
						CMD_UPDATE: begin
							if (match || is_tail) begin
								state_q <= S_EMIT;
							end else begin
								idx_q   <= idx_q + IDX_W'(1);
								state_q <= S_RD;
							end
						end
						CMD_DELETE: begin
							if (shift_q || match) begin
								if (is_tail) begin
									count_q <= count_q - CNT_W'(1);
									state_q <= S_EMIT;
								end else begin
									shift_q <= 1'b1;
									idx_q   <= idx_q + IDX_W'(1);
									state_q <= S_RD;
								end
							end else if (is_tail) begin
								state_q <= S_EMIT;
							end else begin
								idx_q   <= idx_q + IDX_W'(1);
								state_q <= S_RD;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_EMIT: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture and result fields
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			cmd_q   <= req_cmd;
			key_q   <= req_key;
			value_q <= req_value;
		end
		if (state_q == S_EXEC) begin
			res_key_q   <= key_q;
			res_value_q <= value_q;
			case (cmd_q)
				CMD_APPEND: begin
					res_status_q <= is_full ? ST_FULL : ST_OK;
				end
				CMD_SHOW: begin
					res_status_q <= ST_EMPTY;
					res_key_q    <= '0;
					res_value_q  <= '0;
				end
				CMD_DELETE: begin
					res_status_q <= ST_EMPTY;
					res_value_q  <= '0;
				end
				default: begin
					res_status_q <= ST_EMPTY;
				end
			endcase
		end
		if (state_q == S_CMP) begin
			case (cmd_q)
				CMD_UPDATE: begin
					res_status_q <= match ? ST_OK : ST_NOTFOUND;
				end
				CMD_DELETE: begin
					if (!shift_q && match) begin
						res_status_q <= ST_OK;
						res_value_q  <= mem_rdata.value;
					end else if (!shift_q) begin
						res_status_q <= ST_NOTFOUND;
					end
				end
				default: begin
					res_status_q <= res_status_q;
				end
			endcase
		end
	end

endmodule

// File: rtl/okrl_obuf.sv
// Output register: holds one result until the downstream side takes it.
`timescale 1ns / 1ps

module okrl_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  okrl_pkg::result_t din,
	output logic              free,
	output logic              valid,
	input  logic              ready,
	output okrl_pkg::result_t dout
);
	import okrl_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;
	assign dout  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= push || (valid_q && !ready);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= din;
		end
	end

endmodule
